@@ hdl/dcsp_pkg.sv @@
// Package for the DIMACS CNF stream parser: parse mode codes, event and
// error codes, character constants and the result status type.
// No dependencies.
package dcsp_pkg;

	// Parse modes, held in a plain 3-bit state vector.
	localparam logic [2:0] MODE_LINE_START = 3'd0;
	localparam logic [2:0] MODE_CLAUSE     = 3'd1;
	localparam logic [2:0] MODE_LITERAL    = 3'd2;
	localparam logic [2:0] MODE_SKIP       = 3'd3;
	localparam logic [2:0] MODE_ERROR      = 3'd4;

	// Input request kinds.
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Result event kinds.
	localparam logic [1:0] EV_LITERAL    = 2'd0;
	localparam logic [1:0] EV_CLAUSE_END = 2'd1;
	localparam logic [1:0] EV_ERROR      = 2'd2;
	localparam logic [1:0] EV_END_DONE   = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
	localparam logic [1:0] ERR_FULL       = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW   = 2'd3;

	// ASCII characters the parser recognizes.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_LC_C  = 8'h63;
	localparam logic [7:0] CHAR_LC_P  = 8'h70;

	// Width of the magnitude accumulator; larger magnitudes are flagged.
	localparam int MAG_W = 31;

	// Status fields of one result.
	typedef struct packed {
		logic [1:0] event_kind;
		logic [1:0] error_code;
		logic       parse_ok;
		logic       partial_dropped;
	} status_t;

endpackage

@@ hdl/dcsp_core.sv @@
// Parser state registers and the combinational next-state and result logic.
// Depends on dcsp_pkg.
module dcsp_core #(
	parameter int MAX_CLAUSE_LITERALS = 32,
	parameter int LEN_W = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 advance,
	input  logic                 kind,
	input  logic [7:0]           text_byte,
	output logic                 res_valid,
	output dcsp_pkg::status_t    status,
	output logic signed [31:0]   literal_value,
	output logic [LEN_W-1:0]     clause_length
);
	import dcsp_pkg::*;

	logic [2:0]       mode_q, mode_d;
	logic             neg_q, neg_d;
	logic [MAG_W-1:0] acc_q, acc_d;
	logic [LEN_W-1:0] count_q, count_d;
	logic             ovf_q, ovf_d;

	logic             is_digit;
	logic [3:0]       digit;
	logic [MAG_W+3:0] acc_next;
	logic [31:0]      lit_mag;
	logic             has_res;

	assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
	assign digit    = 4'(text_byte - CHAR_ZERO);
	// Multiply by ten as two shifts, then add the new digit.
	assign acc_next = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + (MAG_W+4)'(digit);
	assign lit_mag  = {1'b0, acc_q};

	always_comb begin
		mode_d        = mode_q;
		neg_d         = neg_q;
		acc_d         = acc_q;
		count_d       = count_q;
		ovf_d         = ovf_q;
		has_res       = 1'b0;
		status        = '0;
		literal_value = '0;
		clause_length = '0;

		if (kind == KIND_END) begin
			has_res                = 1'b1;
			status.event_kind      = EV_END_DONE;
			status.parse_ok        = (mode_q != MODE_ERROR);
			status.partial_dropped = (mode_q == MODE_CLAUSE) || (mode_q == MODE_LITERAL);
			mode_d  = MODE_LINE_START;
			neg_d   = 1'b0;
			acc_d   = '0;
			count_d = '0;
			ovf_d   = 1'b0;
		end else begin
			case (mode_q)
				MODE_LINE_START: begin
					if (text_byte == CHAR_LC_C || text_byte == CHAR_LC_P) begin
						mode_d = MODE_SKIP;
					end else if (text_byte == CHAR_ZERO) begin
						// A lone zero on a fresh line is an empty clause.
						count_d           = '0;
						has_res           = 1'b1;
						status.event_kind = EV_CLAUSE_END;
					end else if (text_byte == CHAR_MINUS || is_digit) begin
						count_d = '0;
						mode_d  = MODE_LITERAL;
						ovf_d   = 1'b0;
						neg_d   = (text_byte == CHAR_MINUS);
						acc_d   = (text_byte == CHAR_MINUS) ? '0 : MAG_W'(digit);
					end
				end
				MODE_CLAUSE: begin
					if (text_byte == CHAR_ZERO) begin
						has_res           = 1'b1;
						status.event_kind = EV_CLAUSE_END;
						clause_length     = count_q;
						count_d           = '0;
						mode_d            = MODE_LINE_START;
					end else if (text_byte == CHAR_MINUS || is_digit) begin
						mode_d = MODE_LITERAL;
						ovf_d  = 1'b0;
						neg_d  = (text_byte == CHAR_MINUS);
						acc_d  = (text_byte == CHAR_MINUS) ? '0 : MAG_W'(digit);
					end else if (text_byte != CHAR_LF && text_byte != CHAR_TAB &&
							text_byte != CHAR_SPACE) begin
						has_res           = 1'b1;
						status.event_kind = EV_ERROR;
						status.error_code = ERR_UNEXPECTED;
						mode_d            = MODE_ERROR;
					end
				end
				MODE_LITERAL: begin
					if (is_digit) begin
						// Keep the last in-range magnitude once the limit is passed.
						if (acc_next[MAG_W+3:MAG_W] != '0) begin
							ovf_d = 1'b1;
						end else begin
							acc_d = acc_next[MAG_W-1:0];
						end
					end else if (ovf_q) begin
						has_res           = 1'b1;
						status.event_kind = EV_ERROR;
						status.error_code = ERR_OVERFLOW;
						mode_d            = MODE_ERROR;
					end else if (count_q >= LEN_W'(MAX_CLAUSE_LITERALS)) begin
						has_res           = 1'b1;
						status.event_kind = EV_ERROR;
						status.error_code = ERR_FULL;
						mode_d            = MODE_ERROR;
					end else begin
						has_res           = 1'b1;
						status.event_kind = EV_LITERAL;
						literal_value     = neg_q ? -lit_mag : lit_mag;
						count_d           = count_q + LEN_W'(1);
						mode_d            = MODE_CLAUSE;
						neg_d             = 1'b0;
						acc_d             = '0;
					end
				end
				MODE_SKIP: begin
					if (text_byte == CHAR_LF) begin
						mode_d = MODE_LINE_START;
					end
				end
				default: begin
					// Error mode: bytes are dropped until the end of text.
				end
			endcase
		end
	end

	assign res_valid = item_valid && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_LINE_START;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

@@ hdl/dimacs_cnf_stream_parser.sv @@
// Top level of the DIMACS CNF stream parser: input register, parser core and
// result register on stream handshakes. Depends on dcsp_pkg and dcsp_core.

// The parser takes DIMACS CNF text one byte per request on the slave side
// (tuser = 0 with the character in tdata) and an end-of-text marker as a
// request with tuser = 1. It sustains one request per clock cycle unless a
// result waits on a stalled master side. A request's result is formed in the
// input register and loaded into the result register, where it can be taken;
// the request waits in the input register while its result cannot be loaded.
// The rate rests on the parser state (mode, sign, magnitude, clause count)
// read and rewritten per byte, so each byte sees the state its predecessor
// left. Comment and problem lines are skipped to the newline and the problem
// line is not checked. A literal is reported when any non-digit ends it; that
// character is consumed. A zero in clause position reports a clause end with
// the literal count, and a zero at line start reports an empty clause.
// Magnitudes above 2147483647 give a literal overflow error rather than
// wrapping, and a literal beyond MAX_CLAUSE_LITERALS in one clause gives a
// clause full error. After any error the parser ignores text until the
// end-of-text request, which always yields a summary result and re-arms the
// parser. Bytes that cause no result produce nothing on the master side. The
// input side keeps taking requests while a finished result waits, as long as
// the byte in the input register produces no result or the result register
// is free or being read.
module dimacs_cnf_stream_parser #(
	parameter int MAX_CLAUSE_LITERALS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
	input  logic        s_axis_tuser,  // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] literal_value, then clause_length, error_code, parse_ok,
	// partial_dropped, then zero fill up to a whole byte
	output logic [((32+$clog2(MAX_CLAUSE_LITERALS+1)+4+7)/8)*8-1:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser   // [1:0] event_kind
);
	import dcsp_pkg::*;

	localparam int LEN_W   = $clog2(MAX_CLAUSE_LITERALS + 1);
	localparam int FIELD_W = 32 + LEN_W + 4;
	localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8;

	// Input register.
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// Result register.
	logic                m_valid_q;
	status_t             status_q;
	logic signed [31:0]  literal_q;
	logic [LEN_W-1:0]    length_q;

	// Core outputs.
	logic                res_valid;
	status_t             res_status;
	logic signed [31:0]  res_literal;
	logic [LEN_W-1:0]    res_length;

	logic s_fire;
	logic fire_s1;

	// The byte in the input register moves on when it makes no result or the
	// result register can take one this cycle.
	assign fire_s1       = valid_s1 && (!res_valid || !m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_fire || (valid_s1 && !fire_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			kind_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	dcsp_core #(
		.MAX_CLAUSE_LITERALS(MAX_CLAUSE_LITERALS),
		.LEN_W(LEN_W)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s1),
		.advance      (fire_s1),
		.kind         (kind_s1),
		.text_byte    (byte_s1),
		.res_valid    (res_valid),
		.status       (res_status),
		.literal_value(res_literal),
		.clause_length(res_length)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire_s1 && res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_valid) begin
			status_q  <= res_status;
			literal_q <= res_literal;
			length_q  <= res_length;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = status_q.event_kind;
	assign m_axis_tdata  = OUT_W'({status_q.partial_dropped, status_q.parse_ok,
		status_q.error_code, length_q, literal_q});

	// A new result is never loaded over one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && res_valid) |-> (!m_valid_q || m_axis_tready))
		else $error("result register overwritten while stalled");

	// An error result always carries a nonzero error code.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && status_q.event_kind == EV_ERROR) |-> (status_q.error_code != ERR_NONE))
		else $error("error result without an error code");

	// A literal result carries no clause length, error or summary flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && status_q.event_kind == EV_LITERAL) |->
		(length_q == '0 && status_q.error_code == ERR_NONE &&
		!status_q.parse_ok && !status_q.partial_dropped))
		else $error("literal result with stray status fields");

	// A reported clause never holds more literals than the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && status_q.event_kind == EV_CLAUSE_END) |->
		(length_q <= LEN_W'(MAX_CLAUSE_LITERALS)))
		else $error("clause length above limit");

endmodule
